### sv/round_robin_thread_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin thread scheduler
// Checks in this project are written through these macros.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RRTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrts: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrts: next-cycle check failed");

`endif

### sv/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and codes shared by the scheduler modules.
// ----------------------------------------------------------------------------
package rrts_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_CREATE = 2'd0,
        KIND_EXIT   = 2'd1,
        KIND_YIELD  = 2'd2,
        KIND_JOIN   = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOFREE   = 3'd1,
        ST_SELF     = 3'd2,
        ST_ALREADY  = 3'd3,
        ST_CIRCULAR = 3'd4,
        ST_NONE     = 3'd5,
        ST_UNINIT   = 3'd6
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_SCAN = 2'd2,
        S_DONE = 2'd3
    } t_state;

    // Scan unit test selection
    typedef enum logic {
        SCAN_FREE = 1'b0,
        SCAN_RUN  = 1'b1
    } t_scan_mode;

    // Control from sequencer to scan unit
    typedef struct packed {
        logic       start;
        logic       step;
        t_scan_mode mode;
    } t_scan_cmd;

    // Status from scan unit to sequencer
    typedef struct packed {
        logic hit;
        logic last;
    } t_scan_sts;

    // Saturation limit of the thread counter
    localparam logic [3:0] COUNT_MAX = 4'd15;

endpackage

### sv/round_robin_thread_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Thread-slot table with a round-robin scheduler for create, exit, yield and
// join requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_in_valid / o_in_ready with i_kind and i_target_thread.
//   Result channel:  o_out_valid / i_out_ready with o_status, o_new_thread,
//   o_running_thread and o_thread_count. Every request gives one result.
//   A request is decoded in S_EXEC, then walks the slot table one slot per
//   cycle through the shared scanner (up to SLOT_COUNT slots for yield, exit
//   and join, up to SLOT_COUNT-1 for create), then loads the result register
//   from S_DONE once it is free. Requests that need no scan go from S_EXEC
//   straight to S_DONE. o_in_ready rises in the same cycle as o_out_valid.
//   o_in_ready is high only between requests; one request is in work at a time.
//   The result register lets a new request be taken while the previous result
//   waits; a stalled receiver holds the finished result in the sequencer
//   until the register frees.
//   Reset clears the table, the thread count and the initialized flag; the
//   first create initializes the table with slot 0 as the running thread.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler import rrts_pkg::*; #(
    parameter int SLOT_COUNT = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [3:0] i_target_thread,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic [3:0] o_new_thread,
    output logic [3:0] o_running_thread,
    output logic [3:0] o_thread_count
);

`include "round_robin_thread_scheduler_macros.svh"

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int TW = (SW > 4) ? SW : 4;

    // Sequencer and table state
    t_state                r_state,   n_state;
    logic [SW-1:0]         r_cur,     n_cur;
    logic [3:0]            r_live,    n_live;
    logic                  r_init,    n_init;
    logic [SLOT_COUNT-1:0] r_used,    n_used;
    logic [SLOT_COUNT-1:0] r_active,  n_active;
    logic [SLOT_COUNT-1:0] r_joined,  n_joined;
    logic [SLOT_COUNT-1:0] r_blocked, n_blocked;
    logic                  r_out_valid, n_out_valid;

    // Payload registers
    t_kind                 r_kind,    n_kind;
    logic [3:0]            r_tgt,     n_tgt;
    t_status               r_st,      n_st;
    logic [SW-1:0]         r_newt,    n_newt;
    t_status               r_o_status, n_o_status;
    logic [3:0]            r_o_newt,  n_o_newt;
    logic [3:0]            r_o_run,   n_o_run;
    logic [3:0]            r_o_count, n_o_count;

    // Scanner and joiner memory links
    t_scan_cmd             w_cmd;
    t_scan_sts             w_sts;
    logic [SW-1:0]         w_idx;
    logic                  w_jw_en;
    logic [SW-1:0]         w_joiner;
    logic [TW-1:0]         w_tgt_ext;
    logic [SW-1:0]         w_tgt_idx;
    logic                  w_tgt_out;
    logic                  w_in_fire;
    logic                  w_out_free;

    assign w_tgt_ext  = TW'(r_tgt);
    assign w_tgt_idx  = w_tgt_ext[SW-1:0];
    assign w_tgt_out  = (32'(r_tgt) >= SLOT_COUNT);
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    rrts_scan #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_base    (r_cur),
        .i_used    (r_used),
        .i_active  (r_active),
        .i_blocked (r_blocked),
        .o_sts     (w_sts),
        .o_idx     (w_idx)
    );

    // Joiner slot per thread; read at the current slot
    rrts_ram #(
        .WIDTH (SW),
        .DEPTH (SLOT_COUNT)
    ) u_joiner_ram (
        .i_clk   (i_clk),
        .i_we    (w_jw_en),
        .i_waddr (w_tgt_idx),
        .i_wdata (r_cur),
        .i_raddr (r_cur),
        .o_rdata (w_joiner)
    );

    // Next state and table updates
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_live      = r_live;
        n_init      = r_init;
        n_used      = r_used;
        n_active    = r_active;
        n_joined    = r_joined;
        n_blocked   = r_blocked;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_tgt       = r_tgt;
        n_st        = r_st;
        n_newt      = r_newt;
        n_o_status  = r_o_status;
        n_o_newt    = r_o_newt;
        n_o_run     = r_o_run;
        n_o_count   = r_o_count;
        w_cmd       = '{start: 1'b0, step: 1'b0, mode: SCAN_RUN};
        w_jw_en     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_kind  = t_kind'(i_kind);
                    n_tgt   = i_target_thread;
                    n_newt  = '0;
                    n_st    = ST_OK;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_DONE;
                if (r_kind == KIND_CREATE) begin
                    // Initialize the table on first use, then look for a free slot
                    if (!r_init) begin
                        n_used    = '0;
                        n_active  = '0;
                        n_joined  = '0;
                        n_blocked = '0;
                        n_used[0]   = 1'b1;
                        n_active[0] = 1'b1;
                        n_cur     = '0;
                        n_init    = 1'b1;
                    end
                    w_cmd   = '{start: 1'b1, step: 1'b0, mode: SCAN_FREE};
                    n_state = S_SCAN;
                end else if (!r_init) begin
                    n_st = ST_UNINIT;
                end else begin
                    case (r_kind)
                        KIND_EXIT: begin
                            // Retire current thread and release its joiner
                            if (r_live != 4'd0) begin
                                n_live = r_live - 4'd1;
                            end
                            if (r_joined[r_cur]) begin
                                n_blocked[w_joiner] = 1'b0;
                            end
                            n_active[r_cur] = 1'b0;
                            n_joined[r_cur] = 1'b0;
                            w_cmd   = '{start: 1'b1, step: 1'b0, mode: SCAN_RUN};
                            n_state = S_SCAN;
                        end
                        KIND_YIELD: begin
                            w_cmd   = '{start: 1'b1, step: 1'b0, mode: SCAN_RUN};
                            n_state = S_SCAN;
                        end
                        KIND_JOIN: begin
                            // Check the target; if it can be joined, block the caller and switch
                            if (w_tgt_ext == TW'(r_cur)) begin
                                n_st = ST_SELF;
                            end else if (w_tgt_out || !r_used[w_tgt_idx]
                                         || !r_active[w_tgt_idx]) begin
                                n_st = ST_OK;
                            end else if (r_joined[w_tgt_idx]) begin
                                n_st = ST_ALREADY;
                            end else if (r_joined[r_cur]
                                         && (TW'(w_joiner) == w_tgt_ext)) begin
                                n_st = ST_CIRCULAR;
                            end else begin
                                w_jw_en              = 1'b1;
                                n_blocked[r_cur]     = 1'b1;
                                n_joined[w_tgt_idx]  = 1'b1;
                                w_cmd   = '{start: 1'b1, step: 1'b0, mode: SCAN_RUN};
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_st = ST_UNINIT;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (w_sts.hit) begin
                    n_st    = ST_OK;
                    n_state = S_DONE;
                    if (r_kind == KIND_CREATE) begin
                        // Claim the free slot
                        if (r_live < COUNT_MAX) begin
                            n_live = r_live + 4'd1;
                        end
                        n_used[w_idx]    = 1'b1;
                        n_active[w_idx]  = 1'b1;
                        n_joined[w_idx]  = 1'b0;
                        n_blocked[w_idx] = 1'b0;
                        n_newt           = w_idx;
                    end else begin
                        n_cur = w_idx;
                    end
                end else if (w_sts.last) begin
                    n_st    = (r_kind == KIND_CREATE) ? ST_NOFREE : ST_NONE;
                    n_state = S_DONE;
                end else begin
                    w_cmd = '{start: 1'b0, step: 1'b1, mode: SCAN_RUN};
                end
            end

            S_DONE: begin
                // Hold the result until the output register frees
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_st;
                    n_o_newt    = 4'(TW'(r_newt));
                    n_o_run     = 4'(TW'(r_cur));
                    n_o_count   = r_live;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_live      <= '0;
            r_init      <= 1'b0;
            r_used      <= '0;
            r_active    <= '0;
            r_joined    <= '0;
            r_blocked   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_live      <= n_live;
            r_init      <= n_init;
            r_used      <= n_used;
            r_active    <= n_active;
            r_joined    <= n_joined;
            r_blocked   <= n_blocked;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_tgt      <= n_tgt;
        r_st       <= n_st;
        r_newt     <= n_newt;
        r_o_status <= n_o_status;
        r_o_newt   <= n_o_newt;
        r_o_run    <= n_o_run;
        r_o_count  <= n_o_count;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_new_thread     = r_o_newt;
    assign o_running_thread = r_o_run;
    assign o_thread_count   = r_o_count;

    // Checks
    `RRTS_ASSERT_SAME(a_cur_in_table, i_clk, i_rst_n, 1'b1, (32'(r_cur) < SLOT_COUNT))
    `RRTS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_fire, !o_in_ready)
    `RRTS_ASSERT_NEXT(a_result_loads, i_clk, i_rst_n, (r_state == S_DONE) && w_out_free, o_out_valid && o_in_ready)

endmodule

### sv/rrts_ram.sv
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/rrts_scan.sv
// ----------------------------------------------------------------------------
// rrts_scan
// Shared scanner: tests one slot per cycle while stepped, free or runnable.
// ----------------------------------------------------------------------------
module rrts_scan import rrts_pkg::*; #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_scan_cmd                     i_cmd,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_base,
    input  logic [SLOT_COUNT-1:0]         i_used,
    input  logic [SLOT_COUNT-1:0]         i_active,
    input  logic [SLOT_COUNT-1:0]         i_blocked,
    output t_scan_sts                     o_sts,
    output logic [$clog2(SLOT_COUNT)-1:0] o_idx
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    t_scan_mode    r_mode, n_mode;
    logic [SW-1:0] r_idx,  n_idx;
    logic [CW-1:0] r_left, n_left;
    logic          w_free;
    logic          w_run;

    // Advance the slot pointer with wrap, or load a new scan
    always_comb begin
        n_mode = r_mode;
        n_idx  = r_idx;
        n_left = r_left;
        if (i_cmd.start) begin
            n_mode = i_cmd.mode;
            if (i_cmd.mode == SCAN_RUN) begin
                n_idx  = (i_base == LAST_SLOT) ? '0 : i_base + SW'(1);
                n_left = CW'(SLOT_COUNT);
            end else begin
                n_idx  = SW'(1);
                n_left = CW'(SLOT_COUNT - 1);
            end
        end else if (i_cmd.step) begin
            n_idx  = (r_idx == LAST_SLOT) ? '0 : r_idx + SW'(1);
            n_left = r_left - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= SCAN_FREE;
            r_idx  <= '0;
            r_left <= '0;
        end else begin
            r_mode <= n_mode;
            r_idx  <= n_idx;
            r_left <= n_left;
        end
    end

    // Test the slot under the pointer
    assign w_free = !i_used[r_idx] || !i_active[r_idx];
    assign w_run  = i_used[r_idx] && i_active[r_idx] && !i_blocked[r_idx];

    assign o_sts.hit  = (r_mode == SCAN_RUN) ? w_run : w_free;
    assign o_sts.last = (r_left == CW'(1));
    assign o_idx      = r_idx;

endmodule
